// ===== hdl/nmea_rmc_sentence_parser_defines.svh =====
// Assertion macros shared by the RMC parser checkers
`ifndef NMEA_RMC_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_RMC_SENTENCE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the parser clock, off during reset
`define NRMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the parser clock, off during reset
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nrmc_pkg.sv =====
// Shared types, character codes and helper functions of the RMC sentence parser
package nrmc_pkg;

    // Characters the parser looks for
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    // Fixed positions inside the line
    localparam int HEAD_LEN    = 6;
    localparam int TIME_POS    = 7;
    localparam int TIME_LAST   = 12;
    localparam int DATE_START  = 12;
    localparam int DATE_COMMAS = 8;
    localparam int STAT_COMMAS = 2;
    localparam int FIELD_BYTES = 6;
    localparam int MIN_LINE    = 8;
    localparam int CK_FROM_END = 4;
    localparam int SUM_TAIL    = 5;

    // Command queue between front and back (depth must stay a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // What the front tells the back about one accepted byte
    typedef enum logic [1:0] {
        CMD_QUIET,
        CMD_ERR,
        CMD_EOL
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_LAST,
        BK_FINISH
    } t_back_state;

    // One result item
    typedef struct packed {
        logic       sentence_done;
        logic       sentence_ok;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] fix_status;
        logic       framing_error;
    } t_result;

    // Expected header character at positions 0 to 5
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_R;
            3'd4:    c = CH_M;
            3'd5:    c = CH_C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Uppercase hex digit to value, wrapping on anything else
    function automatic logic [7:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = b - CH_ZERO;
        if (v > 8'd9) begin
            v = v - 8'd7;
        end
        return v;
    endfunction

    // Two decimal digit characters to a byte, modulo 256
    function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        h = hi - CH_ZERO;
        l = lo - CH_ZERO;
        return (h << 3) + (h << 1) + l;
    endfunction

endpackage

// ===== hdl/nrmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module nrmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/nrmc_queue.sv =====
// Short command queue between the byte front end and the back end
module nrmc_queue import nrmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rp];
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hdl/nrmc_front.sv =====
// Byte front end: sentence framing, line store writes and command generation
module nrmc_front import nrmc_pkg::*; #(
    parameter int LINE_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_stall,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_cmd                            o_cmd,
    input  logic                            i_done,
    output logic [$clog2(LINE_DEPTH+1)-1:0] o_line_len,
    output logic                            o_wr_en,
    output logic [$clog2(LINE_DEPTH)-1:0]   o_wr_addr,
    output logic [7:0]                      o_wr_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic          r_collecting, n_collecting;
    logic [CW-1:0] r_fill, n_fill;
    logic [7:0]    r_prev, n_prev;
    logic          r_eol_pend, n_eol_pend;
    logic [CW-1:0] r_line_len, n_line_len;
    logic          accept;

    // Hold input while the queue is full or a line is being analyzed
    assign o_stall = i_q_full || r_eol_pend;
    assign accept  = i_valid && !o_stall;

    // Classify the byte and update framing state
    always_comb begin
        n_collecting = r_collecting;
        n_fill       = r_fill;
        n_prev       = r_prev;
        n_eol_pend   = r_eol_pend && !i_done;
        n_line_len   = r_line_len;
        o_push       = accept;
        o_cmd        = CMD_QUIET;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_fill[AW-1:0];
        o_wr_data    = i_rx_byte;
        if (accept) begin
            if (!r_collecting) begin
                if (i_rx_byte == CH_DOLLAR) begin
                    o_wr_en      = 1'b1;
                    o_wr_addr    = '0;
                    n_fill       = CW'(1);
                    n_prev       = i_rx_byte;
                    n_collecting = 1'b1;
                end
            end else if (r_fill != CW'(LINE_DEPTH)) begin
                o_wr_en = 1'b1;
                n_fill  = r_fill + 1'b1;
                n_prev  = i_rx_byte;
                if (i_rx_byte == CH_DOLLAR) begin
                    o_cmd = CMD_ERR;
                end
                if (i_rx_byte == CH_LF && r_prev == CH_CR) begin
                    o_cmd        = CMD_EOL;
                    n_line_len   = r_fill + 1'b1;
                    n_eol_pend   = 1'b1;
                    n_fill       = '0;
                    n_collecting = 1'b0;
                end
            end else begin
                // Line store full: drop the byte and go back to hunting for '$'
                o_cmd        = CMD_ERR;
                n_fill       = '0;
                n_collecting = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_fill       <= '0;
            r_eol_pend   <= 1'b0;
        end else begin
            r_collecting <= n_collecting;
            r_fill       <= n_fill;
            r_eol_pend   <= n_eol_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_line_len <= n_line_len;
    end

    assign o_line_len = r_line_len;

endmodule

// ===== hdl/nrmc_back.sv =====
// Back end: result output and end-of-line walk over the line store
module nrmc_back import nrmc_pkg::*; #(
    parameter int LINE_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  t_cmd                            i_q_cmd,
    output logic                            o_q_pop,
    input  logic [$clog2(LINE_DEPTH+1)-1:0] i_line_len,
    output logic                            o_done,
    output logic                            o_rd_en,
    output logic [$clog2(LINE_DEPTH)-1:0]   o_rd_addr,
    input  logic [7:0]                      i_rd_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output t_result                         o_result
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    t_back_state r_state, n_state;
    logic [AW-1:0] r_rd_addr;
    logic          r_dv;
    logic [AW-1:0] r_dpos;

    // Captured line contents
    logic       r_hdr_ok;
    logic [7:0] r_sum;
    logic [7:0] r_ck_hi;
    logic [7:0] r_ck_lo;
    logic [7:0] r_time [FIELD_BYTES];
    logic [7:0] r_date [FIELD_BYTES];
    logic [2:0] r_didx;
    logic [3:0] r_dcnt;
    logic [1:0] r_scnt;
    logic       r_sgot;
    logic [7:0] r_status;

    logic    r_out_valid;
    t_result r_out;

    logic          slot_free;
    logic          start;
    logic          load;
    logic [CW-1:0] pos;
    logic [CW:0]   pos_tail;
    logic [2:0]    t_idx;
    logic          last_addr;
    logic [7:0]    ck_hi_v;
    logic [7:0]    ck_lo_v;
    logic [7:0]    want;
    logic          line_ok;
    t_result       res_walk;
    t_result       res_byte;

    assign slot_free = !r_out_valid || !i_stall;
    assign last_addr = (CW'(r_rd_addr) == i_line_len - 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free && i_q_cmd == CMD_EOL) begin
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (last_addr) begin
                    n_state = BK_LAST;
                end
            end
            BK_LAST: begin
                n_state = BK_FINISH;
            end
            BK_FINISH: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_q_pop = 1'b0;
        start   = 1'b0;
        load    = 1'b0;
        o_done  = 1'b0;
        o_rd_en = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop = 1'b1;
                    start   = (i_q_cmd == CMD_EOL);
                    load    = (i_q_cmd != CMD_EOL);
                end
            end
            BK_WALK: begin
                o_rd_en = 1'b1;
            end
            BK_LAST: begin
                o_rd_en = 1'b0;
            end
            BK_FINISH: begin
                load   = slot_free;
                o_done = slot_free;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = r_rd_addr;

    // Sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_rd_addr <= '0;
            r_dv      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= o_rd_en;
            if (start) begin
                r_rd_addr <= '0;
            end else if (o_rd_en) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
        end
    end

    // Position of the byte now on the read port
    always_ff @(posedge i_clk) begin
        r_dpos <= r_rd_addr;
    end

    assign pos      = CW'(r_dpos);
    assign pos_tail = (CW + 1)'(pos) + (CW + 1)'(SUM_TAIL);
    assign t_idx    = 3'(pos - CW'(TIME_POS));

    // Scan each stored byte: header, checksum, time, date and status captures
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_hdr_ok <= 1'b1;
            r_sum    <= '0;
            r_ck_hi  <= '0;
            r_ck_lo  <= '0;
            r_didx   <= '0;
            r_dcnt   <= '0;
            r_scnt   <= '0;
            r_sgot   <= 1'b0;
            r_status <= '0;
            for (int k = 0; k < FIELD_BYTES; k++) begin
                r_time[k] <= '0;
                r_date[k] <= '0;
            end
        end else if (r_dv) begin
            if (pos < CW'(HEAD_LEN) && i_rd_data != head_char(3'(pos))) begin
                r_hdr_ok <= 1'b0;
            end
            if (pos != '0 && pos_tail < (CW + 1)'(i_line_len)) begin
                r_sum <= r_sum ^ i_rd_data;
            end
            if (pos == i_line_len - CW'(CK_FROM_END)) begin
                r_ck_hi <= i_rd_data;
            end
            if (pos == i_line_len - CW'(CK_FROM_END - 1)) begin
                r_ck_lo <= i_rd_data;
            end
            if (pos >= CW'(TIME_POS) && pos <= CW'(TIME_LAST)) begin
                r_time[t_idx] <= i_rd_data;
            end
            // Date: six bytes after the eighth comma counted from position 12
            if (r_dcnt == 4'(DATE_COMMAS)) begin
                if (r_didx < 3'(FIELD_BYTES)) begin
                    r_date[r_didx] <= i_rd_data;
                    r_didx         <= r_didx + 1'b1;
                end
            end else if (pos >= CW'(DATE_START) && i_rd_data == CH_COMMA) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            // Status: the byte after the second comma
            if (r_scnt == 2'(STAT_COMMAS)) begin
                if (!r_sgot) begin
                    r_status <= i_rd_data;
                    r_sgot   <= 1'b1;
                end
            end else if (i_rd_data == CH_COMMA) begin
                r_scnt <= r_scnt + 1'b1;
            end
        end
    end

    // Form the end-of-line result
    assign ck_hi_v = hex_val(r_ck_hi);
    assign ck_lo_v = hex_val(r_ck_lo);
    assign want    = {ck_hi_v[3:0], ck_lo_v[3:0]};
    assign line_ok = r_hdr_ok && (i_line_len >= CW'(MIN_LINE)) && (r_sum == want);

    always_comb begin
        res_walk               = '0;
        res_walk.sentence_done = 1'b1;
        if (line_ok) begin
            res_walk.sentence_ok = 1'b1;
            res_walk.hours       = digit_pair(r_time[0], r_time[1]);
            res_walk.minutes     = digit_pair(r_time[2], r_time[3]);
            res_walk.seconds     = digit_pair(r_time[4], r_time[5]);
            res_walk.day         = digit_pair(r_date[0], r_date[1]);
            res_walk.month       = digit_pair(r_date[2], r_date[3]);
            res_walk.year        = digit_pair(r_date[4], r_date[5]);
            res_walk.fix_status  = r_status;
        end
    end

    // Result of a byte that does not end a line
    always_comb begin
        res_byte               = '0;
        res_byte.framing_error = (i_q_cmd == CMD_ERR);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= (r_state == BK_FINISH) ? res_walk : res_byte;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/nmea_rmc_sentence_parser.sv =====
// NMEA RMC sentence parser: one result per received byte.
// A byte that does not end a line passes through the command queue and the output register to its result.
// A closing LF stalls input while the back end reads the line store
// one byte per cycle through its single read port, then forms the result.
// Throughput: one byte per cycle between lines while the result output is not stalled.
// Reset is synchronous, active low; the line store keeps its contents and is not cleared.
module nmea_rmc_sentence_parser import nrmc_pkg::*; #(
    parameter int LINE_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_sentence_done,
    output logic       o_sentence_ok,
    output logic [7:0] o_hours,
    output logic [7:0] o_minutes,
    output logic [7:0] o_seconds,
    output logic [7:0] o_day,
    output logic [7:0] o_month,
    output logic [7:0] o_year,
    output logic [7:0] o_fix_status,
    output logic       o_framing_error
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    t_cmd          q_in;
    t_cmd          q_out;
    logic          done;
    logic [CW-1:0] line_len;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    t_result       result;

    // Front end: framing and line store writes
    nrmc_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in),
        .i_done     (done),
        .o_line_len (line_len),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // Command queue
    nrmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Line store
    nrmc_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Back end: line analysis and output register
    nrmc_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .i_line_len (line_len),
        .o_done     (done),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    assign o_sentence_done = result.sentence_done;
    assign o_sentence_ok   = result.sentence_ok;
    assign o_hours         = result.hours;
    assign o_minutes       = result.minutes;
    assign o_seconds       = result.seconds;
    assign o_day           = result.day;
    assign o_month         = result.month;
    assign o_year          = result.year;
    assign o_fix_status    = result.fix_status;
    assign o_framing_error = result.framing_error;

endmodule

// ===== hdl/nrmc_checker.sv =====
// Port-level checker for the RMC sentence parser and its bind
`include "nmea_rmc_sentence_parser_defines.svh"

module nrmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic [7:0] i_rx_byte,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_sentence_done,
    input logic       o_sentence_ok,
    input logic [7:0] o_hours,
    input logic [7:0] o_minutes,
    input logic [7:0] o_seconds,
    input logic [7:0] o_day,
    input logic [7:0] o_month,
    input logic [7:0] o_year,
    input logic [7:0] o_fix_status,
    input logic       o_framing_error
);

    // A good sentence is always a finished one
    `NRMC_ASSERT_NOW(a_ok_needs_done, o_valid && o_sentence_ok, o_sentence_done, "ok without done")

    // Fields stay zero unless the sentence passed
    `NRMC_ASSERT_NOW(a_fields_zero, o_valid && !o_sentence_ok, o_hours == 8'h00 && o_minutes == 8'h00 && o_seconds == 8'h00 && o_day == 8'h00 && o_month == 8'h00 && o_year == 8'h00 && o_fix_status == 8'h00, "fields set on a failed sentence")

    // The closing LF never carries a framing error
    `NRMC_ASSERT_NOW(a_done_no_error, o_valid && o_sentence_done, !o_framing_error, "framing error on a finished line")

    // A stalled result holds until transfer
    `NRMC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sentence_done) && $stable(o_sentence_ok) && $stable(o_hours) && $stable(o_minutes) && $stable(o_seconds) && $stable(o_day) && $stable(o_month) && $stable(o_year) && $stable(o_fix_status) && $stable(o_framing_error), "stalled result changed")

    // A stalled input byte holds until transfer
    `NRMC_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_rx_byte), "stalled input changed")

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);

// ===== sim/nmea_rmc_sentence_parser_tb.sv =====
// Self-checking testbench for the NMEA RMC sentence parser with byte-level prediction
module nmea_rmc_sentence_parser_tb import nrmc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = 128;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int REPORT_MAX  = 10;

    // Printable characters used to build sentences
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_ACTIVE = 8'h41;
    localparam logic [7:0] CH_VOID   = 8'h56;

    typedef bit [7:0] t_byte_q [$];

    // How the checksum digits of a generated sentence are written
    typedef enum int {
        SUM_UPPER,
        SUM_LOWER,
        SUM_WRONG
    } t_sum_form;

    // Tracks the line being collected and the result each byte should cause
    class t_rmc_board;
        bit [7:0]    line_buf [LINE_DEPTH];
        int unsigned fill;
        bit          in_line;
        t_result     pending_results [$];
        int          mismatches;
        int          live_bytes;
        int          lines_closed;
        int          lines_good;
        int          framing_hits;

        function bit [7:0] char_at(int unsigned pos);
            if (pos < fill && pos < LINE_DEPTH) begin
                return line_buf[pos];
            end
            return 8'h00;
        endfunction

        // Two decimal characters to a byte, wrapping modulo 256
        function bit [7:0] decimal_pair(int unsigned pos);
            bit [7:0] tens;
            bit [7:0] ones;
            tens = char_at(pos) - CH_ZERO;
            ones = char_at(pos + 1) - CH_ZERO;
            return tens * 8'd10 + ones;
        endfunction

        function bit [3:0] nibble_of(bit [7:0] c);
            bit [7:0] v;
            v = c - CH_ZERO;
            if (v > 8'd9) begin
                v = v - 8'd7;
            end
            return v[3:0];
        endfunction

        // Advance past a number of commas, stopping at the end of the line
        function int unsigned skip_commas(int unsigned pos, int unsigned count);
            while (count > 0 && pos < fill) begin
                if (char_at(pos) == CH_COMMA) begin
                    count--;
                end
                pos++;
            end
            return pos;
        endfunction

        // Check header, length and checksum of a closed line, then pull out its fields
        function t_result judge_line();
            t_result     r;
            bit [7:0]    head [HEAD_LEN];
            bit [7:0]    sum;
            bit [7:0]    want;
            int unsigned date_pos;
            r = '0;
            head = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C};
            for (int unsigned i = 0; i < HEAD_LEN; i++) begin
                if (char_at(i) != head[i]) begin
                    return r;
                end
            end
            if (fill < MIN_LINE) begin
                return r;
            end
            sum = 8'h00;
            for (int unsigned i = 1; i < fill - SUM_TAIL; i++) begin
                sum ^= char_at(i);
            end
            want = {nibble_of(char_at(fill - CK_FROM_END)),
                    nibble_of(char_at(fill - CK_FROM_END + 1))};
            if (sum != want) begin
                return r;
            end
            r.sentence_ok = 1'b1;
            r.hours       = decimal_pair(TIME_POS);
            r.minutes     = decimal_pair(TIME_POS + 2);
            r.seconds     = decimal_pair(TIME_POS + 4);
            date_pos      = skip_commas(DATE_START, DATE_COMMAS);
            r.day         = decimal_pair(date_pos);
            r.month       = decimal_pair(date_pos + 2);
            r.year        = decimal_pair(date_pos + 4);
            r.fix_status  = char_at(skip_commas(0, STAT_COMMAS));
            return r;
        endfunction

        // Note one accepted byte and queue the result it causes
        function void take_byte(bit [7:0] b);
            t_result r;
            r = '0;
            if (!in_line) begin
                if (b == CH_DOLLAR) begin
                    line_buf[0] = b;
                    fill        = 1;
                    in_line     = 1'b1;
                    live_bytes++;
                end
            end else begin
                live_bytes++;
                if (b == CH_DOLLAR) begin
                    r.framing_error = 1'b1;
                end
                if (fill < LINE_DEPTH) begin
                    line_buf[fill] = b;
                    fill++;
                    if (b == CH_LF && fill >= 2 && line_buf[fill - 2] == CH_CR) begin
                        r               = judge_line();
                        r.sentence_done = 1'b1;
                        fill            = 0;
                        in_line         = 1'b0;
                        lines_closed++;
                        lines_good += r.sentence_ok;
                    end
                end else begin
                    // drop the byte and fall back to waiting for a dollar
                    r.framing_error = 1'b1;
                    fill            = 0;
                    in_line         = 1'b0;
                end
            end
            framing_hits += r.framing_error;
            pending_results.push_back(r);
        endfunction

        function string show(t_result r);
            return $sformatf("done=%b ok=%b time=%02h:%02h:%02h date=%02h/%02h/%02h fix=%02h err=%b",
                r.sentence_done, r.sentence_ok, r.hours, r.minutes, r.seconds,
                r.day, r.month, r.year, r.fix_status, r.framing_error);
        endfunction

        function void flag(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("[%0t] %s", $realtime, what);
                $display("    expected %s", show(want));
                $display("    actual   %s", show(got));
            end
        endfunction

        // Compare one result transfer with the oldest expectation
        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                flag("result with nothing expected", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.sentence_done !== want.sentence_done ||
                got.sentence_ok   !== want.sentence_ok   ||
                got.hours         !== want.hours         ||
                got.minutes       !== want.minutes       ||
                got.seconds       !== want.seconds       ||
                got.day           !== want.day           ||
                got.month         !== want.month         ||
                got.year          !== want.year          ||
                got.fix_status    !== want.fix_status    ||
                got.framing_error !== want.framing_error) begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_sentence_done;
    logic       o_sentence_ok;
    logic [7:0] o_hours;
    logic [7:0] o_minutes;
    logic [7:0] o_seconds;
    logic [7:0] o_day;
    logic [7:0] o_month;
    logic [7:0] o_year;
    logic [7:0] o_fix_status;
    logic       o_framing_error;
    t_result    seen_now;

    t_rmc_board  board;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycles        = 0;

    nmea_rmc_sentence_parser #(.LINE_DEPTH(LINE_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_rx_byte       (i_rx_byte),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sentence_done (o_sentence_done),
        .o_sentence_ok   (o_sentence_ok),
        .o_hours         (o_hours),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds),
        .o_day           (o_day),
        .o_month         (o_month),
        .o_year          (o_year),
        .o_fix_status    (o_fix_status),
        .o_framing_error (o_framing_error)
    );

    assign seen_now = {o_sentence_done, o_sentence_ok, o_hours, o_minutes, o_seconds,
                       o_day, o_month, o_year, o_fix_status, o_framing_error};

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check result transfers and pick the next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.match_result(seen_now);
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one byte and hold it until the transfer happens
    task automatic send_byte(input bit [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        board.take_byte(b);
    endtask

    task automatic send_line(input t_byte_q q);
        foreach (q[i]) begin
            send_byte(q[i]);
        end
    endtask

    // Hold off the sender until every queued result has come back
    task automatic settle_results();
        if (board.pending_results.size() != 0) begin
            i_valid <= 1'b0;
        end
        while (board.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_byte_q from_text(input string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic bit [7:0] hex_char(input bit [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return CH_ZERO + 8'(n);
        end
        return (lower ? CH_LO_A : CH_UP_A) + 8'(n) - 8'd10;
    endfunction

    // Wrap a body in dollar, star, checksum digits and CR LF
    function automatic t_byte_q seal(input t_byte_q body, input t_sum_form form);
        t_byte_q  q;
        bit [7:0] sum;
        sum = 8'h00;
        foreach (body[i]) begin
            sum ^= body[i];
        end
        if (form == SUM_WRONG) begin
            sum ^= 8'($urandom_range(1, 255));
        end
        q = {CH_DOLLAR};
        q = {q, body};
        q.push_back(CH_STAR);
        q.push_back(hex_char(sum[7:4], form == SUM_LOWER));
        q.push_back(hex_char(sum[3:0], form == SUM_LOWER));
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        return q;
    endfunction

    function automatic bit [7:0] time_char();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Random RMC body; six middle fields put the date after the ninth comma
    function automatic t_byte_q rmc_body(input int mid_fields, input bit good_head);
        t_byte_q q;
        int      k;
        q = {CH_G, CH_P, CH_R, CH_M, CH_C};
        if (!good_head) begin
            k    = $urandom_range(4);
            q[k] = q[k] ^ 8'($urandom_range(1, 255));
        end
        q.push_back(CH_COMMA);
        repeat (6) q.push_back(time_char());
        if ($urandom_range(1)) begin
            q.push_back(CH_DOT);
            repeat (2) q.push_back(time_char());
        end
        q.push_back(CH_COMMA);
        case ($urandom_range(9))
            0:       q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            1, 2, 3: q.push_back(CH_VOID);
            default: q.push_back(CH_ACTIVE);
        endcase
        repeat (mid_fields) begin
            q.push_back(CH_COMMA);
            repeat ($urandom_range(6)) q.push_back(8'($urandom_range(8'h2E, 8'h5A)));
        end
        q.push_back(CH_COMMA);
        repeat (6) q.push_back(time_char());
        repeat ($urandom_range(3)) q.push_back(CH_COMMA);
        return q;
    endfunction

    // Line that never ends in time: fills the store and overflows it
    function automatic t_byte_q long_line(input bit cr_last);
        t_byte_q  q;
        bit [7:0] b;
        q = {CH_DOLLAR};
        repeat (LINE_DEPTH - 1) begin
            b = 8'($urandom);
            q.push_back(b == CH_CR ? CH_ZERO : b);
        end
        if (cr_last) begin
            q[LINE_DEPTH - 1] = CH_CR;
            q.push_back(CH_LF);
        end else begin
            q.push_back(8'($urandom));
        end
        return q;
    endfunction

    // Mixed random traffic until enough bytes reached the parser
    task automatic run_random(input int target);
        t_byte_q   q;
        t_sum_form form;
        int        start;
        int        pick;
        bit [7:0]  b;
        start = board.live_bytes;
        while (board.live_bytes - start < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                pick = $urandom_range(9);
                form = (pick == 0) ? SUM_LOWER : (pick == 1) ? SUM_WRONG : SUM_UPPER;
                q = rmc_body(($urandom_range(7) != 0) ? 6 : $urandom_range(9),
                             $urandom_range(9) != 0);
                send_line(seal(q, form));
            end else if (pick < 80) begin
                // noise between sentences, ignored by an idle parser
                repeat ($urandom_range(1, 5)) begin
                    do b = 8'($urandom); while (b == CH_DOLLAR);
                    send_byte(b);
                end
            end else if (pick < 90) begin
                q = {CH_DOLLAR};
                repeat ($urandom_range(40)) q.push_back(8'($urandom));
                if ($urandom_range(1)) begin
                    q.push_back(CH_CR);
                    q.push_back(CH_LF);
                end
                send_line(q);
            end else if (pick < 97) begin
                // stray dollar in the middle of a sentence
                q = seal(rmc_body(6, 1'b1), SUM_UPPER);
                q.insert($urandom_range(1, q.size() - 3), CH_DOLLAR);
                send_line(q);
            end else begin
                send_line(long_line($urandom_range(1)));
            end
            if ($urandom_range(19) == 0) begin
                settle_results();
            end
        end
    endtask

    initial begin
        t_byte_q q;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sender idles 36%, receiver 61%
        send_idle_pct = 36;
        recv_idle_pct = 61;
        send_line('{8'h00, 8'hFF, CH_CR, CH_LF, CH_ACTIVE});
        send_line(seal(from_text(
            "GPRMC,235959.99,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W"),
            SUM_UPPER));
        send_line(seal(from_text("GPRMC,000000,V,,,,,,,010100,,"), SUM_UPPER));
        send_line(seal(from_text("GPRMC,091533,A,,,,,,,150623,,"), SUM_LOWER));
        send_line(seal(from_text("GPRMC,120000,A,,,,,,,150623,,"), SUM_WRONG));
        send_line(seal(from_text("GPGGA,120000,A,,,,,,,150623,,"), SUM_UPPER));
        send_line(seal(from_text("GPRMC,1234"), SUM_UPPER));
        q = from_text("$GPRMC");
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        send_line(q);
        send_line(from_text("$GPRMC,12$3456,A,,,,,,,"));
        send_line('{CH_CR, CH_LF});
        send_line(long_line(1'b0));
        send_line(long_line(1'b1));
        settle_results();

        run_random(30);
        settle_results();

        // Receiver busy less, sender idles more
        send_idle_pct = 61;
        recv_idle_pct = 36;
        run_random(30);
        settle_results();

        // Back to back with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(30);
        settle_results();
        repeat (LINE_DEPTH + 16) @(posedge i_clk);

        $display("Run covered %0d parsed bytes, %0d closed lines (%0d valid RMC), %0d framing errors,",
                 board.live_bytes, board.lines_closed, board.lines_good, board.framing_hits);
        $display("across three pacing phases including stalled and back-to-back traffic.");
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never received",
                     board.mismatches, board.pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
